// ===== sv/rqvr_pkg.sv =====
// ----------------------------------------------------------------------------
// Ring queue package
// Sizes, command and status codes, sequencer states and the memory request
// bundle shared by the ring queue modules.
// ----------------------------------------------------------------------------
package rqvr_pkg;

   localparam int DEPTH      = 16;
   localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W      = $clog2(DEPTH + 1);
   localparam int SUM_W      = CNT_W + 1;
   localparam int VALUE_W    = 32;
   localparam int STATUS_W   = 3;
   localparam int COUNT_W    = 5;
   localparam int RSP_DATA_W = 8;

   localparam logic CMD_APPEND = 1'b0;
   localparam logic CMD_REMOVE = 1'b1;

   localparam logic [STATUS_W-1:0] STAT_INSERTED  = 3'd0;
   localparam logic [STATUS_W-1:0] STAT_FULL      = 3'd1;
   localparam logic [STATUS_W-1:0] STAT_REMOVED   = 3'd2;
   localparam logic [STATUS_W-1:0] STAT_EMPTY     = 3'd3;
   localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 3'd4;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SRCH_RD,
      S_SRCH_CMP,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_DONE
   } state_type;

   typedef struct packed {
      logic               we;
      logic [IDX_W-1:0]   waddr;
      logic [VALUE_W-1:0] wdata;
      logic [IDX_W-1:0]   raddr;
   } mem_req_type;

endpackage

// ===== sv/ring_queue_with_value_removal.sv =====
// ----------------------------------------------------------------------------
// Ring queue with value removal
// Circular queue of signed words with append at the tail and removal of the
// first entry that equals a given value.
// ----------------------------------------------------------------------------
// Each request beat carries a command in req_tuser (append or remove) and a
// 32-bit word in req_tdata. Every request yields exactly one response beat
// with a status code and the number of entries held afterwards.
// An append, a refused append or a removal from an empty queue goes from
// idle straight to the done state, which loads the output register. A
// removal reads and compares entries in turn from the head until a match
// or the tail, moves each later entry one slot toward the head, and
// ends in the done state. The pace is set by the single read port and the
// single write port of the entry memory, which the sequencer visits one
// entry at a time. Requests are taken only while the sequencer is idle.
// A response waits in an output register; while the receiver stalls, the
// sequencer holds its finished result and takes no new request.
// Reset empties the queue and clears any pending response; the entry memory
// itself is not cleared, since only occupied slots are ever compared or moved.
// ----------------------------------------------------------------------------
module ring_queue_with_value_removal
   import rqvr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [VALUE_W-1:0]    req_tdata,   // [31:0] value
   input  logic                  req_tuser,   // [0] cmd
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata    // [2:0] status, [7:3] count
);

   mem_req_type         mem_req;
   logic [VALUE_W-1:0]  rd_data;
   logic                out_free;
   logic                out_load;
   logic [STATUS_W-1:0] out_status;
   logic [COUNT_W-1:0]  out_count;
   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [COUNT_W-1:0]  rsp_count_ff;

   assign out_free = !rsp_valid_ff || rsp_tready;

   rqvr_mem u_mem (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   rqvr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_cmd     (req_tuser),
      .in_value   (req_tdata),
      .out_free   (out_free),
      .out_load   (out_load),
      .out_status (out_status),
      .out_count  (out_count),
      .mem_req    (mem_req),
      .rd_data    (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= out_load;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_status_ff <= out_status;
         rsp_count_ff  <= out_count;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_count_ff, rsp_status_ff};

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while a previous one is still in progress");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[2:0] == STAT_FULL |-> rsp_tdata[7:3] == COUNT_W'(DEPTH))
      else $error("full status with a count below the depth");

   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[2:0] == STAT_EMPTY |-> rsp_tdata[7:3] == '0)
      else $error("empty status with a nonzero count");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response beat changed or dropped while the receiver stalled");

endmodule

// ===== sv/rqvr_mem.sv =====
// ----------------------------------------------------------------------------
// Ring queue entry memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rqvr_mem
   import rqvr_pkg::*;
(
   input  logic               clock,
   input  mem_req_type        mem_req,
   output logic [VALUE_W-1:0] rd_data
);

   logic [VALUE_W-1:0] mem_ff [DEPTH];
   logic [VALUE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         mem_ff[mem_req.waddr] <= mem_req.wdata;
      end
      rd_data_ff <= mem_ff[mem_req.raddr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/rqvr_ctrl.sv =====
// ----------------------------------------------------------------------------
// Ring queue sequencer
// Walks the queue through one shared slot adder and one value comparator to
// append, search for a value and close the gap left by a removal.
// ----------------------------------------------------------------------------
module rqvr_ctrl
   import rqvr_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic                in_cmd,
   input  logic [VALUE_W-1:0]  in_value,
   input  logic                out_free,
   output logic                out_load,
   output logic [STATUS_W-1:0] out_status,
   output logic [COUNT_W-1:0]  out_count,
   output mem_req_type         mem_req,
   input  logic [VALUE_W-1:0]  rd_data
);

   state_type           state_ff, state_in;
   logic [CNT_W-1:0]    ptr_ff, ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [IDX_W-1:0]    head_ff, head_in;
   logic [VALUE_W-1:0]  value_ff, value_in;
   logic [STATUS_W-1:0] status_ff, status_in;

   logic [CNT_W-1:0] ptr_nx;
   logic [CNT_W-1:0] count_m1;
   logic [CNT_W-1:0] offset;
   logic [SUM_W-1:0] slot_sum;
   logic [IDX_W-1:0] slot;
   logic             is_full;
   logic             is_empty;
   logic             hit;
   logic             more_search;
   logic             more_shift;

   assign ptr_nx      = ptr_ff + CNT_W'(1);
   assign count_m1    = count_ff - CNT_W'(1);
   assign is_full     = (count_ff == CNT_W'(DEPTH));
   assign is_empty    = (count_ff == '0);
   assign hit         = (rd_data == value_ff);
   assign more_search = (ptr_nx < count_ff);
   assign more_shift  = (ptr_nx < count_m1);

   always_comb begin
      case (state_ff)
         S_IDLE:     offset = count_ff;
         S_SHIFT_RD: offset = ptr_nx;
         default:    offset = ptr_ff;
      endcase
      slot_sum = SUM_W'(head_ff) + SUM_W'(offset);
      if (slot_sum >= SUM_W'(DEPTH)) begin
         slot_sum = slot_sum - SUM_W'(DEPTH);
      end
      slot = slot_sum[IDX_W-1:0];
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (in_valid) begin
               if (in_cmd == CMD_REMOVE && !is_empty) begin
                  state_in = S_SRCH_RD;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_SRCH_RD: state_in = S_SRCH_CMP;
         S_SRCH_CMP: begin
            if (hit && more_search) begin
               state_in = S_SHIFT_RD;
            end else if (!hit && more_search) begin
               state_in = S_SRCH_RD;
            end else begin
               state_in = S_DONE;
            end
         end
         S_SHIFT_RD: state_in = S_SHIFT_WR;
         S_SHIFT_WR: begin
            if (more_shift) begin
               state_in = S_SHIFT_RD;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      ptr_in        = ptr_ff;
      count_in      = count_ff;
      head_in       = head_ff;
      value_in      = value_ff;
      status_in     = status_ff;
      mem_req.we    = 1'b0;
      mem_req.waddr = slot;
      mem_req.wdata = rd_data;
      mem_req.raddr = slot;
      in_ready      = 1'b0;
      out_load      = 1'b0;
      case (state_ff)
         S_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               value_in = in_value;
               ptr_in   = '0;
               if (in_cmd == CMD_APPEND) begin
                  if (is_full) begin
                     status_in = STAT_FULL;
                  end else begin
                     mem_req.we    = 1'b1;
                     mem_req.wdata = in_value;
                     count_in      = count_ff + CNT_W'(1);
                     status_in     = STAT_INSERTED;
                  end
               end else if (is_empty) begin
                  status_in = STAT_EMPTY;
               end
            end
         end
         S_SRCH_CMP: begin
            if (hit) begin
               if (!more_search) begin
                  status_in = STAT_REMOVED;
                  count_in  = count_m1;
                  if (count_m1 == '0) begin
                     head_in = '0;
                  end
               end
            end else begin
               ptr_in = ptr_nx;
               if (!more_search) begin
                  status_in = STAT_NOT_FOUND;
               end
            end
         end
         S_SHIFT_WR: begin
            mem_req.we = 1'b1;
            ptr_in     = ptr_nx;
            if (!more_shift) begin
               status_in = STAT_REMOVED;
               count_in  = count_m1;
               if (count_m1 == '0) begin
                  head_in = '0;
               end
            end
         end
         S_DONE: out_load = out_free;
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         head_ff  <= '0;
         ptr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         head_ff  <= head_in;
         ptr_ff   <= ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff  <= value_in;
      status_ff <= status_in;
   end

   assign out_status = status_ff;
   assign out_count  = COUNT_W'(count_ff);

endmodule

// ===== tb/sv/ring_queue_with_value_removal_chk.sv =====
// ----------------------------------------------------------------------------
// Ring queue response checker
// Watches the request and response streams of the ring queue, keeps its own
// copy of the queue contents, predicts the status and count of every request
// beat and compares each response beat with the oldest prediction.
// ----------------------------------------------------------------------------
module ring_queue_with_value_removal_chk
   import rqvr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [VALUE_W-1:0]    req_tdata,   // [31:0] value
   input  logic                  req_tuser,   // [0] cmd
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,   // [2:0] status, [7:3] count
   output int                    fail_count,
   output int                    pending_count,
   output int                    checked_count,
   output int                    peak_count,
   output logic [4:0]            status_seen
);

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [COUNT_W-1:0]  count;
   } queue_rsp_type;

   logic [VALUE_W-1:0] model_words [DEPTH];
   int                 model_head;
   int                 model_held;
   queue_rsp_type      expected_rsp [$];

   initial begin
      fail_count    = 0;
      pending_count = 0;
      checked_count = 0;
      peak_count    = 0;
      status_seen   = '0;
      model_head    = 0;
      model_held    = 0;
      for (int i = 0; i < DEPTH; i++) begin
         model_words[i] = '0;
      end
   end

   task automatic report_mismatch(input string msg);
      if (fail_count < 40) begin
         $display("[%0t] MISMATCH: %s", $realtime, msg);
      end
      fail_count++;
   endtask

   task automatic predict_queue_op(input logic op, input logic [VALUE_W-1:0] word,
                                   output queue_rsp_type res);
      int hit;
      hit = -1;
      if (op == CMD_APPEND) begin
         if (model_held >= DEPTH) begin
            res.status = STAT_FULL;
         end else begin
            model_words[(model_head + model_held) % DEPTH] = word;
            model_held++;
            res.status = STAT_INSERTED;
         end
      end else if (model_held == 0) begin
         res.status = STAT_EMPTY;
      end else begin
         for (int k = 0; k < model_held; k++) begin
            if (hit < 0 && model_words[(model_head + k) % DEPTH] == word) begin
               hit = k;
            end
         end
         if (hit < 0) begin
            res.status = STAT_NOT_FOUND;
         end else begin
            for (int j = hit; j + 1 < model_held; j++) begin
               model_words[(model_head + j) % DEPTH] =
                  model_words[(model_head + j + 1) % DEPTH];
            end
            model_held--;
            if (model_held == 0) begin
               model_head = 0;
            end
            res.status = STAT_REMOVED;
         end
      end
      res.count = model_held[COUNT_W-1:0];
      if (model_held > peak_count) begin
         peak_count = model_held;
      end
   endtask

   always @(posedge clock) begin : watch_streams
      queue_rsp_type       exp_rsp;
      logic [STATUS_W-1:0] got_status;
      logic [COUNT_W-1:0]  got_count;
      if (reset) begin
         model_head = 0;
         model_held = 0;
         expected_rsp.delete();
      end else begin
         if (req_tvalid && req_tready) begin
            predict_queue_op(req_tuser, req_tdata, exp_rsp);
            expected_rsp.push_back(exp_rsp);
         end
         if (rsp_tvalid && rsp_tready) begin
            got_status = rsp_tdata[STATUS_W-1:0];
            got_count  = rsp_tdata[STATUS_W +: COUNT_W];
            if (expected_rsp.size() == 0) begin
               report_mismatch($sformatf(
                  "response beat with nothing expected: status %0d count %0d",
                  got_status, got_count));
            end else begin
               exp_rsp = expected_rsp.pop_front();
               if (got_status !== exp_rsp.status) begin
                  report_mismatch($sformatf("beat %0d status expected %0d got %0d",
                                            checked_count, exp_rsp.status, got_status));
               end
               if (got_count !== exp_rsp.count) begin
                  report_mismatch($sformatf("beat %0d count expected %0d got %0d",
                                            checked_count, exp_rsp.count, got_count));
               end
               status_seen[exp_rsp.status] = 1'b1;
            end
            checked_count++;
         end
      end
      pending_count = expected_rsp.size();
   end

endmodule

// ===== tb/sv/ring_queue_with_value_removal_tb.sv =====
// ----------------------------------------------------------------------------
// Ring queue testbench
// Drives append and remove requests into the ring queue with random gaps and
// receiver stalls, runs a directed opening and then random fill, drain, mixed
// and noise phases, and gives the verdict from the checker's failure and pending counts.
// ----------------------------------------------------------------------------
module ring_queue_with_value_removal_tb;
   import rqvr_pkg::*;

   typedef enum int {
      MODE_FILL,
      MODE_DRAIN,
      MODE_MIXED,
      MODE_NOISE
   } traffic_mode_type;

   localparam int RANDOM_BEATS = 1300;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [VALUE_W-1:0]    req_tdata  = '0;
   logic                  req_tuser  = CMD_APPEND;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   int         fail_count;
   int         pending_count;
   int         checked_count;
   int         peak_count;
   logic [4:0] status_seen;

   int                 sent_beats  = 0;
   logic               quiet       = 1'b0;
   logic               hold_rsp    = 1'b0;
   logic [VALUE_W-1:0] recent_words [$];

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   ring_queue_with_value_removal u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   ring_queue_with_value_removal_chk u_chk (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .checked_count (checked_count),
      .peak_count    (peak_count),
      .status_seen   (status_seen)
   );

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(99);
      if (roll < 60) begin
         return 0;
      end else if (roll < 90) begin
         return $urandom_range(3, 1);
      end else if (roll < 98) begin
         return $urandom_range(12, 4);
      end
      return $urandom_range(40, 20);
   endfunction

   function automatic logic [VALUE_W-1:0] small_word();
      return VALUE_W'($signed($urandom_range(8)) - 4);
   endfunction

   function automatic logic [VALUE_W-1:0] pick_word(input logic op);
      int roll;
      int idx;
      logic [VALUE_W-1:0] word;
      roll = $urandom_range(99);
      if (op == CMD_REMOVE && recent_words.size() > 0 && roll < 75) begin
         idx  = $urandom_range(recent_words.size() - 1);
         word = recent_words[idx];
         recent_words.delete(idx);
         return word;
      end
      if (roll < 40) begin
         return small_word();
      end else if (roll < 50) begin
         case ($urandom_range(3))
            0: word = 32'h8000_0000;
            1: word = 32'h7FFF_FFFF;
            2: word = 32'hFFFF_FFFF;
            default: word = 32'h0000_0000;
         endcase
         return word;
      end
      return $urandom;
   endfunction

   // Request stays on the bus until the beat is taken.
   task automatic send_op(input logic op, input logic [VALUE_W-1:0] word);
      int gap;
      gap = quiet ? 0 : pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= word;
      do @(posedge clock); while (!req_tready);
      sent_beats++;
      if (op == CMD_APPEND) begin
         recent_words.push_back(word);
         if (recent_words.size() > 24) begin
            void'(recent_words.pop_front());
         end
      end
   endtask

   task automatic pause_until_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      wait (pending_count == 0);
   endtask

   task automatic send_random(input traffic_mode_type mode);
      logic op;
      int   roll;
      roll = $urandom_range(99);
      case (mode)
         MODE_FILL:  op = (roll < 80) ? CMD_APPEND : CMD_REMOVE;
         MODE_DRAIN: op = (roll < 75) ? CMD_REMOVE : CMD_APPEND;
         default:    op = (roll < 50) ? CMD_APPEND : CMD_REMOVE;
      endcase
      if (mode == MODE_NOISE) begin
         send_op(op, $urandom);
      end else begin
         send_op(op, pick_word(op));
      end
   endtask

   initial begin : rsp_side
      int stall_left;
      int ready_left;
      int hold_left;
      stall_left = 0;
      ready_left = 0;
      hold_left  = 0;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            hold_rsp  = 1'b0;
            hold_left = 400;
         end
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else if (quiet) begin
            rsp_tready <= 1'b1;
         end else if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else if (ready_left > 0) begin
            rsp_tready <= 1'b1;
            ready_left--;
         end else begin
            rsp_tready <= 1'b1;
            ready_left = $urandom_range(20);
            stall_left = pick_gap();
         end
      end
   end

   initial begin : watchdog
      #10_000_000;
      $display("Timeout with %0d response beats still expected.", pending_count);
      $display("** ring_queue_with_value_removal: FAILED **");
      $finish;
   end

   initial begin : stimulus
      traffic_mode_type mode;
      int               block_left;
      int               random_sent;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_op(CMD_REMOVE, 32'h0000_0005);
      send_op(CMD_APPEND, 32'h7FFF_FFFF);
      send_op(CMD_APPEND, 32'h8000_0000);
      send_op(CMD_APPEND, 32'hFFFF_FFFF);
      send_op(CMD_APPEND, 32'h0000_0000);
      send_op(CMD_REMOVE, 32'h1234_5678);
      send_op(CMD_REMOVE, 32'hFFFF_FFFF);
      send_op(CMD_REMOVE, 32'h7FFF_FFFF);
      for (int i = 1; i <= 14; i++) begin
         send_op(CMD_APPEND, VALUE_W'(i));
      end
      send_op(CMD_APPEND, 32'h0000_0063);
      send_op(CMD_REMOVE, 32'h0000_0000);
      send_op(CMD_REMOVE, 32'h0000_000E);
      send_op(CMD_REMOVE, 32'h8000_0000);
      pause_until_drained();

      // Receiver holds off while requests keep coming, so the block backs up.
      hold_rsp = 1'b1;
      for (int i = 0; i < 30; i++) begin
         send_random(MODE_FILL);
      end
      pause_until_drained();

      random_sent = 0;
      block_left  = 0;
      mode        = MODE_MIXED;
      while (random_sent < RANDOM_BEATS) begin
         if (block_left == 0) begin
            case ($urandom_range(9))
               0, 1, 2: mode = MODE_FILL;
               3, 4, 5: mode = MODE_DRAIN;
               6, 7:    mode = MODE_MIXED;
               default: mode = MODE_NOISE;
            endcase
            block_left = $urandom_range(60, 20);
            quiet      = ($urandom_range(5) == 0);
            if ($urandom_range(7) == 0) begin
               pause_until_drained();
            end
         end
         send_random(mode);
         block_left--;
         random_sent++;
      end
      quiet = 1'b0;

      @(negedge clock);
      req_tvalid <= 1'b0;
      wait (pending_count == 0);
      repeat (80) @(posedge clock);

      $display("Run covered %0d request beats and %0d checked response beats,",
               sent_beats, checked_count);
      $display("peak fill %0d of %0d; status codes seen (not found .. inserted): %b",
               peak_count, DEPTH, status_seen);
      if (fail_count == 0 && pending_count == 0) begin
         $display("** ring_queue_with_value_removal: PASSED **");
      end else begin
         $display("** ring_queue_with_value_removal: FAILED **");
      end
      $finish;
   end

endmodule
